// ===== rtl/smix_pkg.sv =====
package smix_pkg;

    // number of sample ports on the block and number of inputs actually mixed
    localparam int LANE_COUNT   = 4;
    localparam int MIXED_INPUTS = 4;

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 16;
    localparam int PAN_W    = 16;
    localparam int FACTOR_W = 15;
    localparam int SCALE_W  = 2 * GAIN_W;
    localparam int PROD_W   = SAMPLE_W + SCALE_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int CFG_W    = 64;

    // fixed-point constants
    localparam logic signed [PAN_W-1:0] PAN_ONE     = 16'sd16384;
    localparam logic signed [PAN_W-1:0] PAN_NEG_ONE = -16'sd16384;
    localparam logic [FACTOR_W-1:0]     FACTOR_ONE  = 15'd16384;
    localparam logic [SAMPLE_W-1:0]     OUT_MAX     = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0]     OUT_MIN     = 24'h800000;

    // register reset values
    localparam logic [CFG_W-1:0]  GAIN_RESET   = 64'h1000_1000_1000_1000;
    localparam logic [CFG_W-1:0]  PAN_RESET    = 64'h0;
    localparam logic [GAIN_W-1:0] MASTER_RESET = 16'h1000;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_INPUT_GAINS = 2'd0,
        REG_INPUT_PANS  = 2'd1,
        REG_MASTER_GAIN = 2'd2
    } cfg_index_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ===== rtl/stereo_pan_mixer.sv =====
// stereo_pan_mixer: four mono inputs mixed to one stereo pair
//
// input channel: s_valid/s_ready carry one transaction per sample period, four
// Q1.23 samples and a presence mask. result channel: m_valid/m_ready carry the
// rounded, saturated left and right Q1.23 mix and a clip flag.
// configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (0 input gains, 1 input pans, 2 master gain, 3 ignored); cfg_ready is always
// high. write only while no transaction is in flight.
// path: input acceptance to m_valid runs through five registered stages (gain
// product, pan scale, sample multiply, lane sum, round and saturate).
// throughput: one transaction per cycle; every stage has its own valid bit and
// loads whenever it is empty or the stage behind it moves, so bubbles close up.
// stall: when m_ready is low the result holds and the stages fill up behind it;
// s_ready falls only when all five stages hold data.
// reset: synchronous, active low; empties the pipeline and sets every gain to
// unity, every pan to center.
module stereo_pan_mixer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [smix_pkg::CFG_W-1:0]        cfg_data,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [smix_pkg::SAMPLE_W-1:0] s_sample_zero,
    input  logic signed [smix_pkg::SAMPLE_W-1:0] s_sample_one,
    input  logic signed [smix_pkg::SAMPLE_W-1:0] s_sample_two,
    input  logic signed [smix_pkg::SAMPLE_W-1:0] s_sample_three,
    input  logic [smix_pkg::LANE_COUNT-1:0]   s_present_mask,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [smix_pkg::SAMPLE_W-1:0] m_left_out,
    output logic signed [smix_pkg::SAMPLE_W-1:0] m_right_out,
    output logic                              m_clipped
);

    localparam int LANES = smix_pkg::LANE_COUNT;
    localparam int SW    = smix_pkg::SAMPLE_W;
    localparam int GW    = smix_pkg::GAIN_W;
    localparam int PW    = smix_pkg::PAN_W;
    localparam int FW    = smix_pkg::FACTOR_W;
    localparam int CW    = smix_pkg::SCALE_W;
    localparam int MW    = smix_pkg::PROD_W;
    localparam int AW    = smix_pkg::SUM_W;

    // configuration registers
    logic [smix_pkg::CFG_W-1:0] gains_reg;
    logic [smix_pkg::CFG_W-1:0] pans_reg;
    logic [GW-1:0]              master_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg  <= smix_pkg::GAIN_RESET;
            pans_reg   <= smix_pkg::PAN_RESET;
            master_reg <= smix_pkg::MASTER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                smix_pkg::REG_INPUT_GAINS: gains_reg  <= cfg_data;
                smix_pkg::REG_INPUT_PANS:  pans_reg   <= cfg_data;
                smix_pkg::REG_MASTER_GAIN: master_reg <= cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    // stage valid bits and per-stage load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5     = !v5_reg || m_ready;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // stage 1: mask samples, gain product, clamped pan factors
    smix_pkg::sample_t s_sample [LANES];
    smix_pkg::sample_t smp1_next [LANES];
    logic [CW-1:0]     g1_next   [LANES];
    logic [FW-1:0]     fl1_next  [LANES];
    logic [FW-1:0]     fr1_next  [LANES];
    smix_pkg::sample_t smp1_reg  [LANES];
    logic [CW-1:0]     g1_reg    [LANES];
    logic [FW-1:0]     fl1_reg   [LANES];
    logic [FW-1:0]     fr1_reg   [LANES];

    assign s_sample[0] = s_sample_zero;
    assign s_sample[1] = s_sample_one;
    assign s_sample[2] = s_sample_two;
    assign s_sample[3] = s_sample_three;

    always_comb begin
        logic signed [PW-1:0] pan;
        logic signed [PW-1:0] pan_c;
        for (int i = 0; i < LANES; i++) begin
            pan = $signed(pans_reg[PW*i +: PW]);
            if (pan > smix_pkg::PAN_ONE) begin
                pan_c = smix_pkg::PAN_ONE;
            end else if (pan < smix_pkg::PAN_NEG_ONE) begin
                pan_c = smix_pkg::PAN_NEG_ONE;
            end else begin
                pan_c = pan;
            end
            // left loses the positive part, right the negative part
            if (pan_c > 0) begin
                fl1_next[i] = smix_pkg::FACTOR_ONE - FW'(pan_c);
                fr1_next[i] = smix_pkg::FACTOR_ONE;
            end else begin
                fl1_next[i] = smix_pkg::FACTOR_ONE;
                fr1_next[i] = smix_pkg::FACTOR_ONE - FW'(-pan_c);
            end
            g1_next[i] = CW'(gains_reg[GW*i +: GW]) * CW'(master_reg);
            if (s_present_mask[i] && (i < smix_pkg::MIXED_INPUTS)) begin
                smp1_next[i] = s_sample[i];
            end else begin
                smp1_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            smp1_reg <= smp1_next;
            g1_reg   <= g1_next;
            fl1_reg  <= fl1_next;
            fr1_reg  <= fr1_next;
        end
    end

    // stage 2: channel scale, rounded half up back to q8.24
    smix_pkg::sample_t smp2_reg [LANES];
    logic [CW-1:0]     cl2_next [LANES];
    logic [CW-1:0]     cr2_next [LANES];
    logic [CW-1:0]     cl2_reg  [LANES];
    logic [CW-1:0]     cr2_reg  [LANES];

    always_comb begin
        logic [CW+FW-1:0] tl;
        logic [CW+FW-1:0] tr;
        for (int i = 0; i < LANES; i++) begin
            tl = (CW+FW)'(g1_reg[i]) * (CW+FW)'(fl1_reg[i]) + (CW+FW)'(1 << (FW - 2));
            tr = (CW+FW)'(g1_reg[i]) * (CW+FW)'(fr1_reg[i]) + (CW+FW)'(1 << (FW - 2));
            cl2_next[i] = tl[FW-1 +: CW];
            cr2_next[i] = tr[FW-1 +: CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            smp2_reg <= smp1_reg;
            cl2_reg  <= cl2_next;
            cr2_reg  <= cr2_next;
        end
    end

    // stage 3: sample times channel scale
    logic signed [MW-1:0] pl3_next [LANES];
    logic signed [MW-1:0] pr3_next [LANES];
    logic signed [MW-1:0] pl3_reg  [LANES];
    logic signed [MW-1:0] pr3_reg  [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            pl3_next[i] = MW'(smp2_reg[i]) * MW'($signed({1'b0, cl2_reg[i]}));
            pr3_next[i] = MW'(smp2_reg[i]) * MW'($signed({1'b0, cr2_reg[i]}));
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            pl3_reg <= pl3_next;
            pr3_reg <= pr3_next;
        end
    end

    // stage 4: sum the lanes
    logic signed [AW-1:0] suml4_next, sumr4_next;
    logic signed [AW-1:0] suml4_reg, sumr4_reg;

    always_comb begin
        suml4_next = '0;
        sumr4_next = '0;
        for (int i = 0; i < LANES; i++) begin
            suml4_next = suml4_next + AW'(pl3_reg[i]);
            sumr4_next = sumr4_next + AW'(pr3_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            suml4_reg <= suml4_next;
            sumr4_reg <= sumr4_next;
        end
    end

    // stage 5: round half up to q1.23 and saturate
    logic signed [AW:0]    tl5, tr5;
    logic                  ovl5, ovr5;
    logic signed [SW-1:0]  left5_next, right5_next;
    logic                  clip5_next;
    logic signed [SW-1:0]  left5_reg, right5_reg;
    logic                  clip5_reg;

    always_comb begin
        tl5 = (AW+1)'(suml4_reg) + (AW+1)'(1 << (SW - 1));
        tr5 = (AW+1)'(sumr4_reg) + (AW+1)'(1 << (SW - 1));
        // in range when every bit from the output sign up matches the top bit
        ovl5 = !((&tl5[AW:SW+SW-1]) || !(|tl5[AW:SW+SW-1]));
        ovr5 = !((&tr5[AW:SW+SW-1]) || !(|tr5[AW:SW+SW-1]));
        if (ovl5) begin
            left5_next = tl5[AW] ? $signed(smix_pkg::OUT_MIN) : $signed(smix_pkg::OUT_MAX);
        end else begin
            left5_next = tl5[SW +: SW];
        end
        if (ovr5) begin
            right5_next = tr5[AW] ? $signed(smix_pkg::OUT_MIN) : $signed(smix_pkg::OUT_MAX);
        end else begin
            right5_next = tr5[SW +: SW];
        end
        clip5_next = ovl5 || ovr5;
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            left5_reg  <= left5_next;
            right5_reg <= right5_next;
            clip5_reg  <= clip5_next;
        end
    end

    assign m_left_out  = left5_reg;
    assign m_right_out = right5_reg;
    assign m_clipped   = clip5_reg;

    // a clipped result carries a full-scale value on at least one side
    a_clip_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_clipped) |->
            (m_left_out == $signed(smix_pkg::OUT_MAX) ||
             m_left_out == $signed(smix_pkg::OUT_MIN) ||
             m_right_out == $signed(smix_pkg::OUT_MAX) ||
             m_right_out == $signed(smix_pkg::OUT_MIN)))
        else $error("clip flag without a saturated channel");

    // an accepted transaction always lands in the first stage
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted transaction lost at stage one");

    // input may only stall when every stage is occupied
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

// ===== test/stereo_pan_mixer_test.sv =====
module stereo_pan_mixer_test;

    // spare register slot, writes to it must leave every register untouched
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int LONG_HOLD = 80;
    localparam longint TIMEOUT_LIMIT = 20_000_000;
    localparam longint MIX_MAX = 64'sd8388607;
    localparam longint MIX_MIN = -64'sd8388608;
    // full-scale sample values for the directed cases
    localparam int SMP_TOP    = 8388607;
    localparam int SMP_BOTTOM = -8388608;

    typedef struct {
        smix_pkg::sample_t left;
        smix_pkg::sample_t right;
        logic              clipped;
    } stereo_mix_t;

    // register copies, mix prediction and the queue of mixes still owed by the block
    class stereo_mix_tracker;
        logic [smix_pkg::CFG_W-1:0]  gains;
        logic [smix_pkg::CFG_W-1:0]  pans;
        logic [smix_pkg::GAIN_W-1:0] master;
        stereo_mix_t                 pending_mix[$];
        int                          mismatch_count;
        int                          mixes_checked;
        int                          clip_count;

        function new();
            gains = smix_pkg::GAIN_RESET;
            pans = smix_pkg::PAN_RESET;
            master = smix_pkg::MASTER_RESET;
            mismatch_count = 0;
            mixes_checked = 0;
            clip_count = 0;
        endfunction

        function void load_reg(logic [1:0] idx, logic [smix_pkg::CFG_W-1:0] data);
            case (idx)
                smix_pkg::REG_INPUT_GAINS: gains = data;
                smix_pkg::REG_INPUT_PANS: pans = data;
                smix_pkg::REG_MASTER_GAIN: master = data[smix_pkg::GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // round half toward plus infinity from 47 fraction bits, then saturate
        function longint saturate_mix(longint acc, output bit hit);
            longint r;
            r = (acc + (longint'(1) << 23)) >>> 24;
            hit = 1'b0;
            if (r > MIX_MAX) begin
                hit = 1'b1;
                r = MIX_MAX;
            end else if (r < MIX_MIN) begin
                hit = 1'b1;
                r = MIX_MIN;
            end
            return r;
        endfunction

        function stereo_mix_t mix_period(smix_pkg::sample_t lane_smp[smix_pkg::LANE_COUNT],
                                         logic [3:0] mask);
            stereo_mix_t mix;
            longint sum_l;
            longint sum_r;
            longint g;
            longint p;
            longint cl;
            longint cr;
            longint s;
            longint out_l;
            longint out_r;
            logic signed [smix_pkg::PAN_W-1:0] pan_raw;
            bit hit_l;
            bit hit_r;
            sum_l = 0;
            sum_r = 0;
            for (int i = 0; i < smix_pkg::MIXED_INPUTS; i++) begin
                if (mask[i]) begin
                    s = longint'(lane_smp[i]);
                    g = longint'(gains[smix_pkg::GAIN_W*i +: smix_pkg::GAIN_W])
                        * longint'(master);
                    pan_raw = pans[smix_pkg::PAN_W*i +: smix_pkg::PAN_W];
                    p = longint'(pan_raw);
                    // pans beyond plus or minus one clamp to the rail
                    if (p > longint'(smix_pkg::PAN_ONE)) p = longint'(smix_pkg::PAN_ONE);
                    if (p < longint'(smix_pkg::PAN_NEG_ONE)) p = longint'(smix_pkg::PAN_NEG_ONE);
                    // linear balance factors, channel gain rounded half up
                    cl = (g * (longint'(smix_pkg::FACTOR_ONE) - (p > 0 ? p : 0)) + 8192) >> 14;
                    cr = (g * (longint'(smix_pkg::FACTOR_ONE) + (p < 0 ? p : 0)) + 8192) >> 14;
                    sum_l += s * cl;
                    sum_r += s * cr;
                end
            end
            out_l = saturate_mix(sum_l, hit_l);
            out_r = saturate_mix(sum_r, hit_r);
            mix.left = smix_pkg::sample_t'(out_l);
            mix.right = smix_pkg::sample_t'(out_r);
            mix.clipped = hit_l | hit_r;
            return mix;
        endfunction

        function void take_samples(smix_pkg::sample_t lane_smp[smix_pkg::LANE_COUNT],
                                   logic [3:0] mask);
            pending_mix.insert(pending_mix.size(), mix_period(lane_smp, mask));
        endfunction

        function void compare_mix(smix_pkg::sample_t left, smix_pkg::sample_t right,
                                  logic clipped);
            stereo_mix_t want;
            if (pending_mix.size() == 0) begin
                $display("%0t: mix with nothing outstanding, L=%0d R=%0d clip=%0b",
                         $time, left, right, clipped);
                mismatch_count++;
                return;
            end
            want = pending_mix.pop_front();
            mixes_checked++;
            if (clipped === 1'b1) clip_count++;
            if (left !== want.left) begin
                $display("%0t: left_out expected %0d actual %0d", $time, want.left, left);
                mismatch_count++;
            end
            if (right !== want.right) begin
                $display("%0t: right_out expected %0d actual %0d", $time, want.right, right);
                mismatch_count++;
            end
            if (clipped !== want.clipped) begin
                $display("%0t: clipped expected %0b actual %0b", $time, want.clipped, clipped);
                mismatch_count++;
            end
        endfunction

        function int waiting();
            return pending_mix.size();
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [1:0]                      cfg_index;
    logic [smix_pkg::CFG_W-1:0]      cfg_data;
    logic                            s_valid;
    logic                            s_ready;
    smix_pkg::sample_t               s_sample_zero;
    smix_pkg::sample_t               s_sample_one;
    smix_pkg::sample_t               s_sample_two;
    smix_pkg::sample_t               s_sample_three;
    logic [smix_pkg::LANE_COUNT-1:0] s_present_mask;
    logic                            m_valid;
    logic                            m_ready;
    smix_pkg::sample_t               m_left_out;
    smix_pkg::sample_t               m_right_out;
    logic                            m_clipped;

    stereo_mix_tracker mix_book;
    bit hold_request;
    bit steady_flow;
    int settings_count;

    stereo_pan_mixer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_zero  (s_sample_zero),
        .s_sample_one   (s_sample_one),
        .s_sample_two   (s_sample_two),
        .s_sample_three (s_sample_three),
        .s_present_mask (s_present_mask),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_out     (m_left_out),
        .m_right_out    (m_right_out),
        .m_clipped      (m_clipped)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic smix_pkg::sample_t rand_sample();
        case ($urandom_range(0, 9))
            0: return smix_pkg::sample_t'(smix_pkg::OUT_MAX);
            1: return smix_pkg::sample_t'(smix_pkg::OUT_MIN);
            2, 3: return smix_pkg::sample_t'(int'($urandom_range(0, 8191)) - 4096);
            default: return smix_pkg::sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [smix_pkg::CFG_W-1:0] rand_gains();
        logic [smix_pkg::CFG_W-1:0] v;
        for (int i = 0; i < smix_pkg::LANE_COUNT; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: v[smix_pkg::GAIN_W*i +: smix_pkg::GAIN_W] =
                    smix_pkg::GAIN_W'($urandom_range(0, 8192));
                5, 6: v[smix_pkg::GAIN_W*i +: smix_pkg::GAIN_W] =
                    smix_pkg::GAIN_W'($urandom);
                7: v[smix_pkg::GAIN_W*i +: smix_pkg::GAIN_W] = '0;
                default: v[smix_pkg::GAIN_W*i +: smix_pkg::GAIN_W] = smix_pkg::MASTER_RESET;
            endcase
        end
        return v;
    endfunction

    function automatic logic [smix_pkg::CFG_W-1:0] rand_pans();
        logic [smix_pkg::CFG_W-1:0] v;
        for (int i = 0; i < smix_pkg::LANE_COUNT; i++) begin
            case ($urandom_range(0, 9))
                6, 7: v[smix_pkg::PAN_W*i +: smix_pkg::PAN_W] = smix_pkg::PAN_W'($urandom);
                8: v[smix_pkg::PAN_W*i +: smix_pkg::PAN_W] = smix_pkg::PAN_ONE;
                9: v[smix_pkg::PAN_W*i +: smix_pkg::PAN_W] = smix_pkg::PAN_NEG_ONE;
                default: v[smix_pkg::PAN_W*i +: smix_pkg::PAN_W] =
                    smix_pkg::PAN_W'(int'($urandom_range(0, 32768)) - 16384);
            endcase
        end
        return v;
    endfunction

    // master gain rides in the low bits, the rest of the word is noise
    function automatic logic [smix_pkg::CFG_W-1:0] rand_master();
        logic [smix_pkg::CFG_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v[smix_pkg::GAIN_W-1:0] = smix_pkg::GAIN_W'($urandom_range(0, 8192));
            5, 6, 7: v[smix_pkg::GAIN_W-1:0] = smix_pkg::GAIN_W'($urandom);
            default: v[smix_pkg::GAIN_W-1:0] = smix_pkg::MASTER_RESET;
        endcase
        return v;
    endfunction

    // one input transaction, returns at the falling edge after acceptance with valid still high
    task automatic send_set(input smix_pkg::sample_t lane_smp[smix_pkg::LANE_COUNT],
                            input logic [3:0] mask);
        s_valid <= 1'b1;
        s_sample_zero <= lane_smp[0];
        s_sample_one <= lane_smp[1];
        s_sample_two <= lane_smp[2];
        s_sample_three <= lane_smp[3];
        s_present_mask <= mask;
        do @(posedge aclk); while (!s_ready);
        mix_book.take_samples(lane_smp, mask);
        @(negedge aclk);
    endtask

    task automatic send_four(input int a, input int b, input int c, input int d,
                             input logic [3:0] mask);
        smix_pkg::sample_t lane_smp[smix_pkg::LANE_COUNT];
        lane_smp[0] = smix_pkg::sample_t'(a);
        lane_smp[1] = smix_pkg::sample_t'(b);
        lane_smp[2] = smix_pkg::sample_t'(c);
        lane_smp[3] = smix_pkg::sample_t'(d);
        send_set(lane_smp, mask);
    endtask

    task automatic run_random(input int count);
        smix_pkg::sample_t lane_smp[smix_pkg::LANE_COUNT];
        logic [3:0] mask;
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < smix_pkg::LANE_COUNT; i++) lane_smp[i] = rand_sample();
            mask = ($urandom_range(0, 9) < 4) ? 4'hF : 4'($urandom_range(0, 15));
            send_set(lane_smp, mask);
            if (!steady_flow && $urandom_range(0, 99) < 30) begin
                s_valid <= 1'b0;
                repeat (pick_gap()) @(negedge aclk);
            end
        end
    endtask

    // drop valid and wait for every outstanding mix before touching registers
    task automatic drain_mixes();
        s_valid <= 1'b0;
        while (mix_book.waiting() != 0) @(negedge aclk);
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [smix_pkg::CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        mix_book.load_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic program_all(input logic [smix_pkg::CFG_W-1:0] gains,
                               input logic [smix_pkg::CFG_W-1:0] pans,
                               input logic [smix_pkg::CFG_W-1:0] master);
        drain_mixes();
        program_reg(smix_pkg::REG_INPUT_GAINS, gains);
        program_reg(smix_pkg::REG_INPUT_PANS, pans);
        program_reg(smix_pkg::REG_MASTER_GAIN, master);
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // result side: check every transaction at the rising edge
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                mix_book.compare_mix(m_left_out, m_right_out, m_clipped);
        end
    end

    // result side ready: random stalls, a long hold on request, none in steady flow
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 99) < 25) stall_left = pick_gap();
            end
        end
    end

    // timeout
    initial begin
        #TIMEOUT_LIMIT;
        $display("Regression FAIL");
        $finish;
    end

    // stimulus
    initial begin
        mix_book = new();
        hold_request = 1'b0;
        steady_flow = 1'b0;
        settings_count = 1;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = smix_pkg::REG_INPUT_GAINS;
        cfg_data = '0;
        s_valid = 1'b0;
        s_sample_zero = '0;
        s_sample_one = '0;
        s_sample_two = '0;
        s_sample_three = '0;
        s_present_mask = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // unity gains and center pans: each channel is the saturated sum of present samples
        send_four(0, 0, 0, 0, 4'hF);
        send_four(SMP_TOP, SMP_TOP, SMP_TOP, SMP_TOP, 4'hF);
        send_four(SMP_BOTTOM, SMP_BOTTOM, SMP_BOTTOM, SMP_BOTTOM, 4'hF);
        send_four(SMP_TOP, SMP_BOTTOM, SMP_TOP, SMP_BOTTOM, 4'h0);
        send_four(SMP_TOP, SMP_BOTTOM, SMP_TOP, SMP_BOTTOM, 4'hF);
        send_four(123456, -7, 55, 99, 4'h1);
        send_four(-7, 123456, 55, 99, 4'h2);
        send_four(-7, 55, 123456, 99, 4'h4);
        send_four(-7, 55, 99, 123456, 4'h8);
        send_four(SMP_TOP, 0, 0, 0, 4'h1);
        send_four(SMP_BOTTOM, 0, 0, 0, 4'h1);
        send_four(-1, -1, -1, -1, 4'hF);
        send_four(1, 1, 1, 1, 4'hF);
        send_four(SMP_TOP, SMP_TOP, 5, 5, 4'h3);
        send_four(5, 5, SMP_BOTTOM, SMP_BOTTOM, 4'hC);
        // alternating bit patterns
        send_four(5592405, -5592406, 0, 0, 4'h3);

        // zero input gains at full master: everything mixes to silence
        program_all('0, rand_pans(), {48'h0, 16'hFFFF});
        run_random(20);

        // every gain at its top: heavy clipping
        program_all({smix_pkg::CFG_W{1'b1}}, smix_pkg::PAN_RESET, {48'h0, 16'hFFFF});
        run_random(30);

        // half gains put odd samples exactly on the rounding midpoint
        program_all(64'h0800_0800_0800_0800, smix_pkg::PAN_RESET,
                    {48'h0, smix_pkg::MASTER_RESET});
        send_four(1, 0, 0, 0, 4'h1);
        send_four(-1, 0, 0, 0, 4'h1);
        send_four(3, 0, 0, 0, 4'h1);
        send_four(-3, 0, 0, 0, 4'h1);
        send_four(1, 1, 1, -1, 4'hF);
        send_four(-1, -1, -1, 1, 4'hF);

        // pans past the rails clamp, then a write to the spare slot changes nothing
        program_all(smix_pkg::GAIN_RESET,
                    {smix_pkg::PAN_ONE, smix_pkg::PAN_NEG_ONE, 16'h7FFF, 16'h8000},
                    {48'h0, smix_pkg::MASTER_RESET});
        program_reg(REG_SPARE, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        run_random(80);

        // random settings, one phase without any idling, one with a long output hold
        for (int phase = 0; phase < 8; phase++) begin
            program_all(rand_gains(), rand_pans(), rand_master());
            if (phase == 2) steady_flow = 1'b1;
            if (phase == 5) begin
                hold_request = 1'b1;
                steady_flow = 1'b1;
                run_random(40);
                steady_flow = 1'b0;
            end
            run_random(180);
            steady_flow = 1'b0;
        end

        drain_mixes();
        repeat (20) @(posedge aclk);
        $display("covered %0d mixes over %0d register settings, %0d of them clipped",
                 mix_book.mixes_checked, settings_count, mix_book.clip_count);
        $display("including silent, saturating, midpoint rounding and clamped pan cases");
        if (mix_book.mismatch_count == 0 && mix_book.waiting() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/smix_pkg.sv
rtl/stereo_pan_mixer.sv
test/stereo_pan_mixer_test.sv
